### hw/rtl/acrf_pkg.sv
// Shared types, constants and offset maps of the accelerator control register file.
`default_nettype none

package acrf_pkg;

   localparam int DATA_W      = 32;
   localparam int ADDR_W      = 16;
   localparam int PLAIN_IDX_W = 4;
   localparam int STATUS_W    = 6;
   localparam int DEPTH_W     = 6;

   // region select, address bits [15:12]
   localparam logic [3:0] REGION_CTRL = 4'h0;
   localparam logic [3:0] REGION_SFU  = 4'h5;
   localparam logic [3:0] REGION_ATT  = 4'h6;
   localparam logic [3:0] REGION_DMA  = 4'h7;

   // special offsets inside a region
   localparam logic [11:0] CTRL_DOORBELL    = 12'h000;
   localparam logic [11:0] CTRL_PEND_STATUS = 12'h008;
   localparam logic [11:0] CTRL_VERSION     = 12'h020;
   localparam logic [11:0] CTRL_CAPS        = 12'h024;
   localparam logic [11:0] CORE_STATUS      = 12'h004;
   localparam logic [11:0] CORE_CMD         = 12'h024;
   localparam logic [11:0] CORE_DEPTH       = 12'h02C;

   localparam logic [DATA_W-1:0] VERSION_VALUE = 32'h0001_0000;
   localparam logic [DATA_W-1:0] CAPS_BASE     = 32'h0000_0070;

   // core status bits
   localparam int ST_DONE  = 1;
   localparam int ST_ERROR = 2;
   localparam int ST_EMPTY = 4;
   localparam int ST_FULL  = 5;
   localparam logic [STATUS_W-1:0] STATUS_RESET = 6'h12;
   localparam logic [STATUS_W-1:0] STATUS_W1C   = 6'h06;

   // plain register counts
   localparam int CTRL_REGS = 6;
   localparam int CORE_REGS = 9;
   localparam int SFU_REGS  = 7;
   localparam int ATT_REGS  = 11;
   localparam int DMA_REGS  = 8;

   typedef struct packed {
      logic                   hit;
      logic [PLAIN_IDX_W-1:0] idx;
   } map_type;

   typedef struct packed {
      logic                   unmapped;
      logic                   ctrl_sel;
      logic                   core_sel;
      logic                   sfu_sel;
      logic                   att_sel;
      logic                   dma_sel;
      logic [1:0]             core_idx;
      logic                   plain_hit;
      logic [PLAIN_IDX_W-1:0] plain_idx;
      logic                   doorbell;
      logic                   pend_status;
      logic                   version;
      logic                   caps;
      logic                   core_status;
      logic                   core_cmd;
      logic                   core_depth;
   } dec_type;

   function automatic map_type ctrl_map(input logic [3:0] word);
      map_type m;
      m.hit = 1'b1;
      unique case (word)
         4'd1:    m.idx = 4'd0;
         4'd3:    m.idx = 4'd1;
         4'd4:    m.idx = 4'd2;
         4'd5:    m.idx = 4'd3;
         4'd6:    m.idx = 4'd4;
         4'd7:    m.idx = 4'd5;
         default: begin
            m.hit = 1'b0;
            m.idx = 4'd0;
         end
      endcase
      return m;
   endfunction

   function automatic map_type core_map(input logic [3:0] word);
      map_type m;
      m.hit = 1'b1;
      unique case (word)
         4'd0:    m.idx = 4'd0;
         4'd2:    m.idx = 4'd1;
         4'd3:    m.idx = 4'd2;
         4'd4:    m.idx = 4'd3;
         4'd5:    m.idx = 4'd4;
         4'd6:    m.idx = 4'd5;
         4'd7:    m.idx = 4'd6;
         4'd9:    m.idx = 4'd7;
         4'd13:   m.idx = 4'd8;
         default: begin
            m.hit = 1'b0;
            m.idx = 4'd0;
         end
      endcase
      return m;
   endfunction

   // SFU, attention and DMA share a layout: word 0, then words 2 up to a last word
   function automatic map_type block_map(input logic [3:0] word, input logic [3:0] last);
      map_type m;
      m.hit = 1'b0;
      m.idx = 4'd0;
      if (word == 4'd0) begin
         m.hit = 1'b1;
      end else if (word >= 4'd2 && word <= last) begin
         m.hit = 1'b1;
         m.idx = word - 4'd1;
      end
      return m;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/acrf_if.sv
// Request and response channel interfaces of the register file.
`default_nettype none

interface acrf_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic [15:0] address;
   logic [31:0] write_data;

   modport source (output valid, output operation, output address, output write_data,
                   input ready);
   modport sink   (input valid, input operation, input address, input write_data,
                   output ready);
endinterface

interface acrf_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] read_data;
   logic        unmapped;

   modport source (output valid, output read_data, output unmapped, input ready);
   modport sink   (input valid, input read_data, input unmapped, output ready);
endinterface

`default_nettype wire

### hw/rtl/acrf_decode.sv
// Address decoder: region, core index, plain register index and special offsets.
`default_nettype none

module acrf_decode #(
   parameter int NUM_CORES = 4
) (
   input  wire logic [acrf_pkg::ADDR_W-1:0] address,
   output acrf_pkg::dec_type                dec
);

   logic [3:0]       region;
   logic [11:0]      off;
   logic [3:0]       word;
   logic             word_ok;
   acrf_pkg::map_type m;

   assign region  = address[15:12];
   assign off     = address[11:0];
   assign word    = off[5:2];
   assign word_ok = (off[11:6] == 6'd0) && (off[1:0] == 2'd0);

   always_comb begin
      dec          = '0;
      dec.ctrl_sel = (region == acrf_pkg::REGION_CTRL);
      dec.core_sel = (region != 4'd0) && (region <= 4'(NUM_CORES));
      dec.sfu_sel  = (region == acrf_pkg::REGION_SFU);
      dec.att_sel  = (region == acrf_pkg::REGION_ATT);
      dec.dma_sel  = (region == acrf_pkg::REGION_DMA);
      dec.unmapped = !(dec.ctrl_sel || dec.core_sel || dec.sfu_sel
                       || dec.att_sel || dec.dma_sel);
      dec.core_idx = 2'(region - 4'd1);

      priority if (dec.ctrl_sel) m = acrf_pkg::ctrl_map(word);
      else if (dec.core_sel)     m = acrf_pkg::core_map(word);
      else if (dec.sfu_sel)      m = acrf_pkg::block_map(word, 4'd7);
      else if (dec.att_sel)      m = acrf_pkg::block_map(word, 4'd11);
      else                       m = acrf_pkg::block_map(word, 4'd8);

      dec.plain_hit = word_ok && m.hit && !dec.unmapped;
      dec.plain_idx = m.idx;

      dec.doorbell    = dec.ctrl_sel && (off == acrf_pkg::CTRL_DOORBELL);
      dec.pend_status = dec.ctrl_sel && (off == acrf_pkg::CTRL_PEND_STATUS);
      dec.version     = dec.ctrl_sel && (off == acrf_pkg::CTRL_VERSION);
      dec.caps        = dec.ctrl_sel && (off == acrf_pkg::CTRL_CAPS);
      dec.core_status = dec.core_sel && (off == acrf_pkg::CORE_STATUS);
      dec.core_cmd    = dec.core_sel && (off == acrf_pkg::CORE_CMD);
      dec.core_depth  = dec.core_sel && (off == acrf_pkg::CORE_DEPTH);
   end

endmodule

`default_nettype wire

### hw/rtl/acrf_bank.sv
// Bank of plain read/write registers addressed by a decoded index.
`default_nettype none

module acrf_bank #(
   parameter int DEPTH = 8
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             sel,
   input  wire logic                             we,
   input  wire logic [acrf_pkg::PLAIN_IDX_W-1:0] idx,
   input  wire logic [acrf_pkg::DATA_W-1:0]      wdata,
   output logic      [acrf_pkg::DATA_W-1:0]      rdata
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [acrf_pkg::DATA_W-1:0] regs_ff [DEPTH];
   logic [IDX_W-1:0]            idx_l;

   assign idx_l = idx[IDX_W-1:0];
   assign rdata = sel ? regs_ff[idx_l] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) regs_ff[i] <= '0;
      end else if (we) begin
         regs_ff[idx_l] <= wdata;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/acrf_core.sv
// One per-core command block: plain registers, status bits and queue depth count.
`default_nettype none

module acrf_core #(
   parameter int FULL_LEVEL = 32
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        sel,
   input  wire logic                        fire,
   input  wire logic                        wr,
   input  wire acrf_pkg::dec_type           dec,
   input  wire logic [acrf_pkg::DATA_W-1:0] wdata,
   output logic      [acrf_pkg::DATA_W-1:0] rdata
);

   logic [acrf_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [acrf_pkg::DEPTH_W-1:0]  depth_ff, depth_in, depth_inc;
   logic [acrf_pkg::DATA_W-1:0]   bank_rd;
   logic                          wr_en;

   assign wr_en     = fire && sel && wr;
   assign depth_inc = depth_ff + 6'd1;

   acrf_bank #(.DEPTH(acrf_pkg::CORE_REGS)) u_bank (
      .clock (clock),
      .reset (reset),
      .sel   (sel && dec.plain_hit),
      .we    (wr_en && dec.plain_hit),
      .idx   (dec.plain_idx),
      .wdata (wdata),
      .rdata (bank_rd)
   );

   always_comb begin
      status_in = status_ff;
      depth_in  = depth_ff;
      if (wr_en && dec.core_status) begin
         status_in = status_ff & ~(wdata[acrf_pkg::STATUS_W-1:0] & acrf_pkg::STATUS_W1C);
      end
      if (wr_en && dec.core_cmd) begin
         depth_in = depth_inc;
         if (depth_inc >= 6'(FULL_LEVEL)) status_in[acrf_pkg::ST_FULL] = 1'b1;
         status_in[acrf_pkg::ST_EMPTY] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff <= acrf_pkg::STATUS_RESET;
         depth_ff  <= '0;
      end else begin
         status_ff <= status_in;
         depth_ff  <= depth_in;
      end
   end

   assign rdata = bank_rd
                | ((sel && dec.core_status) ? 32'(status_ff) : '0)
                | ((sel && dec.core_depth)  ? 32'(depth_ff)  : '0);

   a_depth_bump: assert property (@(posedge clock) disable iff (reset)
      wr_en && dec.core_cmd |=> depth_ff == $past(depth_ff) + 6'd1)
      else $error("command write did not bump queue depth");

   a_not_empty: assert property (@(posedge clock) disable iff (reset)
      wr_en && dec.core_cmd |=> !status_ff[acrf_pkg::ST_EMPTY])
      else $error("EMPTY still set after command write");

   a_full_sticky: assert property (@(posedge clock) disable iff (reset)
      status_ff[acrf_pkg::ST_FULL] |=> status_ff[acrf_pkg::ST_FULL])
      else $error("FULL dropped without reset");

endmodule

`default_nettype wire

### hw/rtl/accelerator_control_register_file.sv
// Accelerator control register file: 64 KiB register window, one 32-bit word per access.
//
// req carries one access per word: operation (0 read, 1 write), byte address and
// write_data. rsp returns one word per access: read_data (zero for writes and for
// offsets without a register) and unmapped (address outside every region).
// Both channels use valid/ready; a word moves when both are high.
//
// A request is held in the request register, then decoded and registered in the
// response register, which drives rsp. Throughput is one access per cycle while
// rsp is not stalled: the request register feeds decode and the register update
// combinationally, and both land in the response register together.
// Register state changes when the access moves from the request register to the
// response register, so every access sees all earlier ones in order.
// When rsp is stalled the response register holds; the request register still
// takes one more word, then req ready drops until rsp drains.
// Reset (synchronous) empties both stages and returns every register to its
// reset value: zero, except core status which comes up with DONE and EMPTY set.
`default_nettype none

module accelerator_control_register_file #(
   parameter int NUM_CORES  = 4,
   parameter int FULL_LEVEL = 32
) (
   input wire logic  clock,
   input wire logic  reset,
   acrf_req_if.sink  req,
   acrf_rsp_if.source rsp
);

   // request stage
   logic                          s1_valid_ff, s1_valid_in;
   logic                          s1_op_ff;
   logic [acrf_pkg::ADDR_W-1:0]   s1_addr_ff;
   logic [acrf_pkg::DATA_W-1:0]   s1_data_ff;
   // response stage
   logic                          s2_valid_ff, s2_valid_in;
   logic [acrf_pkg::DATA_W-1:0]   s2_rdata_ff, s2_rdata_in;
   logic                          s2_unmapped_ff;

   logic                          req_acc, s1_fire, rsp_acc;
   acrf_pkg::dec_type             dec;

   logic                          doorbell_ff, doorbell_in;
   logic                          wr_en;
   logic [acrf_pkg::DATA_W-1:0]   ctrl_rd, sfu_rd, att_rd, dma_rd, cores_rd, rd_raw;
   logic [NUM_CORES-1:0][acrf_pkg::DATA_W-1:0] core_rd;

   assign s1_fire   = s1_valid_ff && (!s2_valid_ff || rsp.ready);
   assign req.ready = !s1_valid_ff || s1_fire;
   assign req_acc   = req.valid && req.ready;
   assign rsp_acc   = s2_valid_ff && rsp.ready;
   assign wr_en     = s1_fire && s1_op_ff;

   assign s1_valid_in = req_acc || (s1_valid_ff && !s1_fire);
   assign s2_valid_in = s1_fire || (s2_valid_ff && !rsp_acc);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_op_ff   <= req.operation;
         s1_addr_ff <= req.address;
         s1_data_ff <= req.write_data;
      end
      if (s1_fire) begin
         s2_rdata_ff    <= s2_rdata_in;
         s2_unmapped_ff <= dec.unmapped;
      end
   end

   acrf_decode #(.NUM_CORES(NUM_CORES)) u_decode (
      .address (s1_addr_ff),
      .dec     (dec)
   );

   // control region: doorbell sets pending, pending status write-1 clears it
   always_comb begin
      doorbell_in = doorbell_ff;
      if (wr_en && dec.doorbell) doorbell_in = 1'b1;
      if (wr_en && dec.pend_status && s1_data_ff[0]) doorbell_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) doorbell_ff <= 1'b0;
      else       doorbell_ff <= doorbell_in;
   end

   logic [acrf_pkg::DATA_W-1:0] ctrl_bank_rd;

   acrf_bank #(.DEPTH(acrf_pkg::CTRL_REGS)) u_ctrl (
      .clock (clock),
      .reset (reset),
      .sel   (dec.ctrl_sel && dec.plain_hit),
      .we    (wr_en && dec.ctrl_sel && dec.plain_hit),
      .idx   (dec.plain_idx),
      .wdata (s1_data_ff),
      .rdata (ctrl_bank_rd)
   );

   assign ctrl_rd = ctrl_bank_rd
                  | (dec.pend_status ? 32'(doorbell_ff) : '0)
                  | (dec.version ? acrf_pkg::VERSION_VALUE : '0)
                  | (dec.caps ? (32'(NUM_CORES) | acrf_pkg::CAPS_BASE) : '0);

   acrf_bank #(.DEPTH(acrf_pkg::SFU_REGS)) u_sfu (
      .clock (clock),
      .reset (reset),
      .sel   (dec.sfu_sel && dec.plain_hit),
      .we    (wr_en && dec.sfu_sel && dec.plain_hit),
      .idx   (dec.plain_idx),
      .wdata (s1_data_ff),
      .rdata (sfu_rd)
   );

   acrf_bank #(.DEPTH(acrf_pkg::ATT_REGS)) u_att (
      .clock (clock),
      .reset (reset),
      .sel   (dec.att_sel && dec.plain_hit),
      .we    (wr_en && dec.att_sel && dec.plain_hit),
      .idx   (dec.plain_idx),
      .wdata (s1_data_ff),
      .rdata (att_rd)
   );

   acrf_bank #(.DEPTH(acrf_pkg::DMA_REGS)) u_dma (
      .clock (clock),
      .reset (reset),
      .sel   (dec.dma_sel && dec.plain_hit),
      .we    (wr_en && dec.dma_sel && dec.plain_hit),
      .idx   (dec.plain_idx),
      .wdata (s1_data_ff),
      .rdata (dma_rd)
   );

   for (genvar c = 0; c < NUM_CORES; c++) begin : g_core
      acrf_core #(.FULL_LEVEL(FULL_LEVEL)) u_core (
         .clock (clock),
         .reset (reset),
         .sel   (dec.core_sel && (dec.core_idx == 2'(c))),
         .fire  (s1_fire),
         .wr    (s1_op_ff),
         .dec   (dec),
         .wdata (s1_data_ff),
         .rdata (core_rd[c])
      );
   end

   always_comb begin
      cores_rd = '0;
      for (int c = 0; c < NUM_CORES; c++) cores_rd = cores_rd | core_rd[c];
   end

   assign rd_raw      = ctrl_rd | cores_rd | sfu_rd | att_rd | dma_rd;
   assign s2_rdata_in = s1_op_ff ? '0 : rd_raw;

   assign rsp.valid     = s2_valid_ff;
   assign rsp.read_data = s2_rdata_ff;
   assign rsp.unmapped  = s2_unmapped_ff;

   a_write_reads_zero: assert property (@(posedge clock) disable iff (reset)
      s1_fire && s1_op_ff |=> s2_rdata_ff == '0)
      else $error("write word returned nonzero read data");

   a_unmapped_zero: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && s2_unmapped_ff |-> s2_rdata_ff == '0)
      else $error("unmapped access returned data");

   a_doorbell_sets: assert property (@(posedge clock) disable iff (reset)
      wr_en && dec.doorbell |=> doorbell_ff)
      else $error("doorbell write did not set pending");

   a_ready_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> s1_valid_ff && s2_valid_ff && !rsp.ready)
      else $error("request stalled without a full pipeline");

endmodule

`default_nettype wire
